/* rtl/ile_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the indexed list engine.
// No dependencies.
package ile_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;   // width of the position field
  localparam int LEN_W    = 7;   // width of the length_after field
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // compare width: holds both a position and a count without truncation
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_APPEND = 2'd2,
    KIND_DELETE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast from the controller to every cell in the chain
  typedef struct packed {
    logic              ins;   // open a slot at pos and write data
    logic              del;   // close the slot at pos
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] data;
  } ile_ctrl_t;

endpackage

/* rtl/ile_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one entry, shifts toward or
// away from the head on insert/delete. Depends on ile_pkg.
module ile_cell
  import ile_pkg::*;
(
  input  logic              clk,
  input  ile_ctrl_t         ctrl,
  input  logic [CMP_W-1:0]  idx,
  input  logic [DATA_W-1:0] left_value,
  input  logic [DATA_W-1:0] right_value,
  output logic [DATA_W-1:0] value,
  output logic [DATA_W-1:0] read_tap
);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (idx > ctrl.pos) begin
        value_nxt = left_value;
      end else if (idx == ctrl.pos) begin
        value_nxt = ctrl.data;
      end
    end else if (ctrl.del) begin
      if (idx >= ctrl.pos) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value    = value_r;
  // only the addressed cell drives its value onto the read OR bus
  assign read_tap = (idx == ctrl.pos) ? value_r : '0;

endmodule

/* rtl/indexed_list_engine_top.sv */
`timescale 1ns / 1ps
// Indexed list engine top: request decode, entry count, cell chain and
// result register. Depends on ile_pkg and ile_cell.
//
// Holds an ordered list of up to CAPACITY (64) signed 32-bit values in a
// row of cells. Each request (read, insert before position, append, delete)
// completes at the clock edge that accepts it: an insert or delete shifts every
// cell behind the position at that same edge, and a read selects the addressed
// cell through an OR bus. One request is taken every cycle; the result
// appears in the output register in the cycle after acceptance and the input
// keeps flowing as long as that register is free or being taken. Reset clears
// the entry count and the output valid, so the block is ready after reset.
module indexed_list_engine_top
  import ile_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_data_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [1:0]               out_status,
  output logic [LEN_W-1:0]         out_length_after
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [DATA_W-1:0] out_rval_r, out_rval_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [LEN_W-1:0]  out_len_r;

  logic              fire;
  ile_ctrl_t         ctrl;
  logic [CMP_W-1:0]  pos_x, cnt_x;
  logic              full;
  logic [DATA_W-1:0] read_bus;

  logic [DATA_W-1:0] cell_value [CAPACITY];
  logic [DATA_W-1:0] cell_tap   [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;
  assign pos_x    = CMP_W'(in_position);
  assign cnt_x    = CMP_W'(count_r);
  assign full     = (count_r == CNT_W'(CAPACITY));

  // OR bus: at most one cell tap is nonzero
  always_comb begin
    read_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_bus = read_bus | cell_tap[i];
    end
  end

  always_comb begin
    ctrl           = '0;
    ctrl.pos       = pos_x;
    ctrl.data      = in_data_value;
    out_hit_nxt    = 1'b0;
    out_rval_nxt   = '0;
    out_status_nxt = ST_DONE;
    count_nxt      = count_r;
    case (kind_t'(in_kind))
      KIND_READ: begin
        if (pos_x < cnt_x) begin
          out_hit_nxt  = 1'b1;
          out_rval_nxt = read_bus;
        end else begin
          out_status_nxt = ST_RANGE;
        end
      end
      KIND_INSERT: begin
        if (pos_x > cnt_x) begin
          out_status_nxt = ST_RANGE;
        end else if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          ctrl.ins = fire;
        end
      end
      KIND_APPEND: begin
        ctrl.pos = cnt_x;
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          ctrl.ins = fire;
        end
      end
      KIND_DELETE: begin
        if (pos_x < cnt_x) begin
          ctrl.del = fire;
        end else begin
          out_status_nxt = ST_RANGE;
        end
      end
      default: begin
        out_status_nxt = ST_RANGE;
      end
    endcase
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_hit_r    <= out_hit_nxt;
      out_rval_r   <= out_rval_nxt;
      out_status_r <= out_status_nxt;
      out_len_r    <= LEN_W'(count_nxt);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_v, right_v;
    if (g == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[g+1];
    end
    ile_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .idx         (CMP_W'(g)),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[g]),
      .read_tap    (cell_tap[g])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_read_value   = out_rval_r;
  assign out_status       = out_status_r;
  assign out_length_after = out_len_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.del |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ins && ctrl.del))
    else $error("insert and delete in the same cycle");

  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> out_status_r == ST_DONE)
    else $error("hit with error status");

  a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_len_r == LEN_W'(count_r))
    else $error("length_after differs from entry count");

endmodule
